// ----- rtl/sflc_pkg.sv -----
package sflc_pkg;

  localparam int MaxPayloadDefault = 1024;

  localparam logic [7:0] MAGIC_LO = 8'h81;
  localparam logic [7:0] MAGIC_HI = 8'h7E;
  localparam logic [7:0] PAT_ZERO = 8'h00;
  localparam logic [7:0] PAT_ONES = 8'hFF;
  localparam logic [7:0] PAT_ALT  = 8'h55;
  localparam logic [15:0] HEADER_BYTES = 16'd10;

  localparam logic [1:0] MODE_ZERO   = 2'd0;
  localparam logic [1:0] MODE_ONES   = 2'd1;
  localparam logic [1:0] MODE_ALT    = 2'd2;
  localparam logic [1:0] MODE_FRAMED = 2'd3;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LIM_MS = 2'd1;
  localparam logic [1:0] REG_LIM_BY = 2'd2;
  localparam logic [1:0] REG_SEED   = 2'd3;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_FRAME_OK = 3'd1;
  localparam logic [2:0] EV_CRC_ERR  = 3'd2;
  localparam logic [2:0] EV_BAD_LEN  = 3'd3;
  localparam logic [2:0] EV_TIMEOUT  = 3'd4;
  localparam logic [2:0] EV_MISMATCH = 3'd5;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  event_code;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
    logic [31:0] lost_frames;
    logic [31:0] reordered_frames;
    logic [31:0] duplicate_frames;
    logic [31:0] timeout_count;
    logic [31:0] magic_count;
    logic [31:0] pattern_errors;
    logic [31:0] byte_total;
  } out_word_t;

  // classified word handed from the parser to the statistics stage
  typedef struct packed {
    logic [2:0]  event_code;
    logic        magic;
    logic        frame_pass;
    logic [31:0] seq;
  } cls_word_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

// ----- rtl/sflc_front.sv -----
module sflc_front #(
  parameter int MAX_PAYLOAD = sflc_pkg::MaxPayloadDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  sflc_pkg::in_word_t word,
  input  logic [1:0]         link_mode,
  input  logic [31:0]        sync_limit_ms,
  input  logic [31:0]        sync_limit_bytes,
  input  logic [15:0]        crc_seed,
  output sflc_pkg::cls_word_t cls
);
  import sflc_pkg::*;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEAD    = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_TRAILER = 2'd3;
  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt, len_r, len_nxt, crc_r, crc_nxt, tcrc_r, tcrc_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [31:0] seq_r, seq_nxt, tmark_r, tmark_nxt, bmark_r, bmark_nxt;
  logic [15:0] pos_inc, crc_upd, tcrc_full;
  logic [31:0] bcnt;

  // parse one byte; state holds while a constant mode runs
  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; len_nxt = len_r; crc_nxt = crc_r;
    tcrc_nxt = tcrc_r; prev_nxt = prev_r; seq_nxt = seq_r;
    tmark_nxt = tmark_r; bmark_nxt = bmark_r;
    pos_inc = pos_r + 16'd1;
    crc_upd = crc_byte(crc_r, word.rx_byte);
    tcrc_full = {word.rx_byte, tcrc_r[7:0]};
    bcnt = (bmark_r == '1) ? bmark_r : bmark_r + 32'd1;
    cls = '0;
    cls.seq = seq_r;
    if (link_mode != MODE_FRAMED) begin
      case (link_mode)
        MODE_ZERO: if (word.rx_byte != PAT_ZERO) cls.event_code = EV_MISMATCH;
        MODE_ONES: if (word.rx_byte != PAT_ONES) cls.event_code = EV_MISMATCH;
        default:   if (word.rx_byte != PAT_ALT)  cls.event_code = EV_MISMATCH;
      endcase
    end else begin
      bmark_nxt = bcnt;
      case (phase_r)
        PH_HUNT: begin
          if (prev_r == MAGIC_LO && word.rx_byte == MAGIC_HI) begin
            cls.magic = 1'b1;
            crc_nxt = crc_byte(crc_byte(crc_seed, MAGIC_LO), MAGIC_HI);
            pos_nxt = 16'd2; phase_nxt = PH_HEAD; prev_nxt = '0;
            tmark_nxt = word.now_ms; bmark_nxt = '0;
          end else begin
            prev_nxt = word.rx_byte;
            if ((word.now_ms - tmark_r) >= sync_limit_ms || bcnt >= sync_limit_bytes) begin
              cls.event_code = EV_TIMEOUT;
              tmark_nxt = word.now_ms; bmark_nxt = '0;
            end
          end
        end
        PH_HEAD: begin
          crc_nxt = crc_upd;
          pos_nxt = pos_inc;
          if (pos_r == 16'd2) len_nxt = {8'h00, word.rx_byte};
          else if (pos_r == 16'd3) len_nxt = {word.rx_byte, len_r[7:0]};
          else if (pos_r == 16'd4) seq_nxt[7:0] = word.rx_byte;
          else if (pos_r == 16'd5) seq_nxt[15:8] = word.rx_byte;
          else if (pos_r == 16'd6) seq_nxt[23:16] = word.rx_byte;
          else if (pos_r == 16'd7) seq_nxt[31:24] = word.rx_byte;
          if (pos_inc == 16'd4 && (len_nxt == '0 || len_nxt > MaxLen)) begin
            cls.event_code = EV_BAD_LEN;
            phase_nxt = PH_HUNT; pos_nxt = '0; prev_nxt = '0;
          end else if (pos_inc >= HEADER_BYTES) begin
            phase_nxt = PH_PAYLOAD; pos_nxt = '0;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt = crc_upd;
          pos_nxt = pos_inc;
          if (pos_inc >= len_r) begin
            phase_nxt = PH_TRAILER; pos_nxt = '0;
          end
        end
        default: begin
          if (pos_r == '0) begin
            tcrc_nxt = {8'h00, word.rx_byte}; pos_nxt = 16'd1;
          end else begin
            tcrc_nxt = tcrc_full;
            if (tcrc_full == crc_r) begin
              cls.event_code = EV_FRAME_OK; cls.frame_pass = 1'b1;
            end else begin
              cls.event_code = EV_CRC_ERR;
            end
            phase_nxt = PH_HUNT; pos_nxt = '0; prev_nxt = '0;
            tmark_nxt = word.now_ms; bmark_nxt = '0;
          end
        end
      endcase
    end
  end

  // advance parser state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT; pos_r <= '0; len_r <= '0; prev_r <= '0;
      crc_r <= 16'hFFFF; tcrc_r <= '0; seq_r <= '0; tmark_r <= '0; bmark_r <= '0;
    end else if (take) begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; len_r <= len_nxt; prev_r <= prev_nxt;
      crc_r <= crc_nxt; tcrc_r <= tcrc_nxt; seq_r <= seq_nxt;
      tmark_r <= tmark_nxt; bmark_r <= bmark_nxt;
    end
  end

endmodule

// ----- rtl/sflc_back.sv -----
module sflc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  sflc_pkg::cls_word_t cls,
  output sflc_pkg::out_word_t res
);
  import sflc_pkg::*;

  logic [31:0] good_r, bad_r, lost_r, reord_r, dup_r, tmo_r, magic_r, pat_r, bytes_r;
  logic [31:0] good_nxt, bad_nxt, lost_nxt, reord_nxt, dup_nxt, tmo_nxt, magic_nxt;
  logic [31:0] pat_nxt, bytes_nxt;
  logic [31:0] next_seq_r, next_seq_nxt, high_r, high_nxt;
  logic        sv_r, sv_nxt;
  logic [31:0] gap;
  logic [32:0] lost_sum;

  // update counters and sequence tracking
  always_comb begin
    good_nxt = good_r; bad_nxt = bad_r; lost_nxt = lost_r; reord_nxt = reord_r;
    dup_nxt = dup_r; tmo_nxt = tmo_r; magic_nxt = magic_r; pat_nxt = pat_r;
    bytes_nxt = sat_inc(bytes_r);
    next_seq_nxt = next_seq_r; high_nxt = high_r; sv_nxt = sv_r;
    gap = cls.seq - next_seq_r;
    lost_sum = {1'b0, lost_r} + {1'b0, gap};
    if (cls.magic) magic_nxt = sat_inc(magic_r);
    if (cls.event_code == EV_TIMEOUT) tmo_nxt = sat_inc(tmo_r);
    if (cls.event_code == EV_MISMATCH) pat_nxt = sat_inc(pat_r);
    if (cls.event_code == EV_CRC_ERR || cls.event_code == EV_BAD_LEN) bad_nxt = sat_inc(bad_r);
    if (cls.frame_pass) begin
      if (!sv_r) begin
        next_seq_nxt = cls.seq + 32'd1; high_nxt = cls.seq; sv_nxt = 1'b1;
        good_nxt = sat_inc(good_r);
      end else if (cls.seq >= next_seq_r) begin
        lost_nxt = lost_sum[32] ? '1 : lost_sum[31:0];
        good_nxt = sat_inc(good_r);
        next_seq_nxt = cls.seq + 32'd1;
        if (cls.seq > high_r) high_nxt = cls.seq;
      end else if (cls.seq == high_r) begin
        dup_nxt = sat_inc(dup_r);
      end else begin
        reord_nxt = sat_inc(reord_r);
      end
    end
    res.event_code = cls.event_code;
    res.good_frames = good_nxt; res.bad_frames = bad_nxt; res.lost_frames = lost_nxt;
    res.reordered_frames = reord_nxt; res.duplicate_frames = dup_nxt;
    res.timeout_count = tmo_nxt; res.magic_count = magic_nxt;
    res.pattern_errors = pat_nxt; res.byte_total = bytes_nxt;
  end

  // hold counters between words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_r <= '0; bad_r <= '0; lost_r <= '0; reord_r <= '0; dup_r <= '0;
      tmo_r <= '0; magic_r <= '0; pat_r <= '0; bytes_r <= '0;
      next_seq_r <= '0; high_r <= '0; sv_r <= 1'b0;
    end else if (take) begin
      good_r <= good_nxt; bad_r <= bad_nxt; lost_r <= lost_nxt; reord_r <= reord_nxt;
      dup_r <= dup_nxt; tmo_r <= tmo_nxt; magic_r <= magic_nxt; pat_r <= pat_nxt;
      bytes_r <= bytes_nxt; next_seq_r <= next_seq_nxt; high_r <= high_nxt; sv_r <= sv_nxt;
    end
  end

endmodule

// ----- rtl/sflc_fifo.sv -----
module sflc_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  logic [W-1:0] mem_r [2];
  logic [1:0]   cnt_r;
  logic         wp_r, rp_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  // two-entry queue: store, drop and count words
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ----- rtl/seq_frame_link_checker.sv -----
// Framed serial link checker: one received byte per word, one result word per
// input word. Words are taken whenever the queue is not full; the parser
// classifies a byte in the cycle it is pushed, a two-entry queue holds the
// classified word, and the statistics stage updates all counters as that word
// is popped. The push side goes full only once two results are waiting unread.
// Configuration writes are always ready.
module seq_frame_link_checker #(
  parameter int MAX_PAYLOAD = sflc_pkg::MaxPayloadDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  sflc_pkg::in_word_t  in_word,
  output logic                empty,
  input  logic                pop,
  output sflc_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import sflc_pkg::*;

  logic [1:0]  mode_r;
  logic [31:0] lim_ms_r, lim_by_r;
  logic [15:0] seed_r;
  logic        take_in, take_out;
  cls_word_t   cls_in, cls_out;

  assign cfg_ready = 1'b1;
  assign take_in  = push && !full;
  assign take_out = pop && !empty;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FRAMED; lim_ms_r <= 32'd50; lim_by_r <= 32'd4096; seed_r <= 16'hFFFF;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_r <= cfg_data[1:0];
        REG_LIM_MS: lim_ms_r <= cfg_data;
        REG_LIM_BY: lim_by_r <= cfg_data;
        REG_SEED:   seed_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  sflc_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk, .rst_n, .take(take_in), .word(in_word), .link_mode(mode_r),
    .sync_limit_ms(lim_ms_r), .sync_limit_bytes(lim_by_r), .crc_seed(seed_r),
    .cls(cls_in)
  );

  sflc_fifo #(.W($bits(cls_word_t))) u_fifo (
    .clk, .rst_n, .wr(take_in), .wdata(cls_in), .rd(take_out), .rdata(cls_out),
    .full, .empty
  );

  sflc_back u_back (
    .clk, .rst_n, .take(take_out), .cls(cls_out), .res(out_word)
  );

endmodule
